FILE: design/cfcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfcr_pkg: shared types and constants of the frame command responder
// Item kinds, register indexes, peripheral ids, frame constants and the
// peripheral read-back function.
// ----------------------------------------------------------------------------
package cfcr_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] reg_idx_t;
  typedef logic [7:0] byte_t;
  typedef logic [2:0] led_t;
  typedef logic [2:0] byte_cnt_t;

  localparam kind_t KIND_RX = 2'd0;
  localparam kind_t KIND_PG = 2'd1;
  localparam kind_t KIND_SW = 2'd2;

  localparam reg_idx_t REG_COMMAND = 2'd0;
  localparam reg_idx_t REG_REQUEST = 2'd1;
  localparam reg_idx_t REG_DATA    = 2'd2;

  localparam byte_t COMMAND_CODE_RST = 8'h01;
  localparam byte_t REQUEST_CODE_RST = 8'h02;
  localparam byte_t DATA_CODE_RST    = 8'h03;

  localparam byte_cnt_t FRAME_BYTES = 3'd5;
  localparam byte_cnt_t LAST_BYTE   = 3'd4;
  localparam byte_t     SUM_OK      = 8'hFF;
  localparam byte_t     DATA_HIGH   = 8'h00;

  localparam byte_t ID_RED   = 8'd0;
  localparam byte_t ID_GREEN = 8'd1;
  localparam byte_t ID_BLUE  = 8'd2;
  localparam byte_t ID_PG    = 8'd3;
  localparam byte_t ID_STAT1 = 8'd4;
  localparam byte_t ID_STAT2 = 8'd5;
  localparam byte_t ID_SW    = 8'd6;
  localparam byte_t NUM_LEDS = 8'd3;

  function automatic byte_t periph_data(input byte_t id, input led_t leds,
                                        input logic pg, input logic s1,
                                        input logic s2, input logic sw);
    byte_t d;
    d = '0;
    case (id)
      ID_RED:   d = leds[0] ? 8'h40 : 8'h00;
      ID_GREEN: d = leds[1] ? 8'h80 : 8'h00;
      ID_BLUE:  d = leds[2] ? 8'h20 : 8'h00;
      ID_PG:    d = {5'd0, pg, 2'd0};
      ID_STAT1: d = {4'd0, s1, 3'd0};
      ID_STAT2: d = {6'd0, s2, 1'b0};
      ID_SW:    d = {7'd0, sw};
      default:  d = '0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: design/checksummed_frame_command_responder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_command_responder: serial frame parser and responder
// Parses five-byte checksummed frames, drives three LEDs and sends data
// frames in reply to commands, requests and pin-change events.
// ----------------------------------------------------------------------------
// An input item is parsed in the cycle it is accepted; an item that calls
// for a reply places a frame in a one-entry holding register, from which the
// byte serialiser takes it and sends five output items, one per cycle when
// the output is not stalled. The input is stalled while the holding register
// is full: for one cycle after a reply when the serialiser is idle, otherwise
// until the last byte of the frame being sent is taken. Items that give no
// reply are taken every cycle while the holding register is empty; replying
// items are paced by the serialiser, as each reply waits until the frame before it is sent.
// The configuration port is always ready.
module checksummed_frame_command_responder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cfcr_pkg::kind_t   in_kind,
  input  wire cfcr_pkg::byte_t   in_rx_byte,
  input  wire logic              in_pg_level,
  input  wire logic              in_stat1_level,
  input  wire logic              in_stat2_level,
  input  wire logic              in_sw_level,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cfcr_pkg::byte_t        out_tx_byte,
  output logic                   out_tx_last,
  output logic                   out_led_red,
  output logic                   out_led_green,
  output logic                   out_led_blue,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire cfcr_pkg::reg_idx_t cfg_index,
  input  wire cfcr_pkg::byte_t   cfg_data
);
  import cfcr_pkg::*;

  byte_t     command_code_r, request_code_r, data_code_r;
  byte_cnt_t count_r, count_nxt;
  byte_t     sum_r, sum_nxt;
  byte_t     type_r, type_nxt;
  byte_t     target_r, target_nxt;
  byte_t     value_r, value_nxt;
  led_t      led_r, led_nxt;

  logic      emit;
  byte_t     emit_id, emit_data, whole_sum;

  logic      frm_valid_r;
  byte_t     frm_dc_r, frm_id_r, frm_data_r, frm_chk_r;
  led_t      frm_led_r;

  logic      busy_r;
  byte_cnt_t idx_r;
  byte_t     ser_dc_r, ser_id_r, ser_data_r, ser_chk_r;
  led_t      ser_led_r;

  logic      in_fire, out_fire, last_fire, load;

  assign cfg_ready = 1'b1;
  assign in_stall  = frm_valid_r;
  assign in_fire   = in_valid && !frm_valid_r;
  assign out_fire  = busy_r && !out_stall;
  assign last_fire = out_fire && (idx_r == LAST_BYTE);
  assign load      = frm_valid_r && (!busy_r || last_fire);

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    type_nxt   = type_r;
    target_nxt = target_r;
    value_nxt  = value_r;
    led_nxt    = led_r;
    emit       = 1'b0;
    emit_id    = '0;
    emit_data  = '0;
    whole_sum  = sum_r + in_rx_byte;
    case (in_kind)
      KIND_PG: begin
        emit      = 1'b1;
        emit_id   = ID_PG;
        emit_data = periph_data(ID_PG, led_r, in_pg_level, in_stat1_level,
                                in_stat2_level, in_sw_level);
      end
      KIND_SW: begin
        emit      = 1'b1;
        emit_id   = ID_SW;
        emit_data = periph_data(ID_SW, led_r, in_pg_level, in_stat1_level,
                                in_stat2_level, in_sw_level);
      end
      KIND_RX: begin
        if (count_r == '0) begin
          if (in_rx_byte == command_code_r || in_rx_byte == request_code_r ||
              in_rx_byte == data_code_r) begin
            type_nxt  = in_rx_byte;
            sum_nxt   = in_rx_byte;
            count_nxt = 3'd1;
          end
        end else begin
          sum_nxt = whole_sum;
          if (count_r == 3'd1) target_nxt = in_rx_byte;
          if (count_r == 3'd3) value_nxt = in_rx_byte;
          if (count_r == LAST_BYTE) begin
            count_nxt = '0;
            sum_nxt   = '0;
            if (whole_sum == SUM_OK) begin
              if (type_r == command_code_r) begin
                if (target_r < NUM_LEDS) led_nxt[target_r[1:0]] = (value_r != '0);
                emit      = 1'b1;
                emit_id   = target_r;
                emit_data = value_r;
              end else if (type_r == request_code_r) begin
                emit      = 1'b1;
                emit_id   = target_r;
                emit_data = periph_data(target_r, led_r, in_pg_level,
                                        in_stat1_level, in_stat2_level,
                                        in_sw_level);
              end
            end
          end else begin
            count_nxt = count_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_code_r <= COMMAND_CODE_RST;
      request_code_r <= REQUEST_CODE_RST;
      data_code_r    <= DATA_CODE_RST;
      count_r        <= '0;
      sum_r          <= '0;
      led_r          <= '0;
      frm_valid_r    <= 1'b0;
      busy_r         <= 1'b0;
      idx_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COMMAND: command_code_r <= cfg_data;
          REG_REQUEST: request_code_r <= cfg_data;
          REG_DATA:    data_code_r    <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        led_r   <= led_nxt;
      end
      if (in_fire && emit) frm_valid_r <= 1'b1;
      else if (load)       frm_valid_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (last_fire) begin
        busy_r <= 1'b0;
      end else if (out_fire) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      type_r   <= type_nxt;
      target_r <= target_nxt;
      value_r  <= value_nxt;
    end
    if (in_fire && emit) begin
      frm_dc_r   <= data_code_r;
      frm_id_r   <= emit_id;
      frm_data_r <= emit_data;
      frm_chk_r  <= ~(data_code_r + emit_id + DATA_HIGH + emit_data);
      frm_led_r  <= led_nxt;
    end
    if (load) begin
      ser_dc_r   <= frm_dc_r;
      ser_id_r   <= frm_id_r;
      ser_data_r <= frm_data_r;
      ser_chk_r  <= frm_chk_r;
      ser_led_r  <= frm_led_r;
    end
  end

  always_comb begin
    case (idx_r)
      3'd0:    out_tx_byte = ser_dc_r;
      3'd1:    out_tx_byte = ser_id_r;
      3'd2:    out_tx_byte = DATA_HIGH;
      3'd3:    out_tx_byte = ser_data_r;
      default: out_tx_byte = ser_chk_r;
    endcase
  end

  assign out_valid     = busy_r;
  assign out_tx_last   = (idx_r == FRAME_BYTES - 3'd1);
  assign out_led_red   = ser_led_r[0];
  assign out_led_green = ser_led_r[1];
  assign out_led_blue  = ser_led_r[2];

endmodule
`default_nettype wire
